FILE: src/phm_pkg.sv
// Shared types, constants and the per-stage arctangent function of the heading pipeline.
`default_nettype none

package phm_pkg;

  localparam int FIELD_W           = 32;
  localparam int HEAD_W            = 20;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 40;

  // Datapath of the rotator
  localparam int XY_W       = 64;
  localparam int TURN_FRAC  = 40;
  localparam int Z_W        = TURN_FRAC + 2;
  localparam int NORM_BIT   = 58;
  localparam int NORM_STEPS = 6;

  // Angle scaling to millidegrees
  localparam int ZC_W    = TURN_FRAC - 2;
  localparam int ZL_W    = ZC_W / 2;
  localparam int ZH_W    = ZC_W - ZL_W;
  localparam int SCALE_W = 19;
  localparam int PL_W    = ZL_W + SCALE_W;
  localparam int PH_W    = ZH_W + SCALE_W;
  localparam int SUM_W   = ZC_W + SCALE_W;
  localparam int MDEG_W  = SUM_W - TURN_FRAC;

  localparam logic [SCALE_W-1:0] MDEG_PER_TURN = 19'd360000;

  localparam logic signed [HEAD_W-1:0] HEAD_DOWN  = 20'sd270000;
  localparam logic signed [HEAD_W-1:0] HEAD_UP    = 20'sd90000;
  localparam logic signed [HEAD_W-1:0] HEAD_LEFT  = 20'sd180000;
  localparam logic signed [HEAD_W-1:0] HEAD_RIGHT = 20'sd0;

  localparam real TWO_PI = 6.283185307179586476925;

  typedef struct packed {
    logic vert;    // dx is zero
    logic dx_pos;  // dx > 0
    logic dy_pos;  // dy > 0
    logic neg;     // dx and dy differ in sign, dy nonzero
  } phm_flags_t;

  // Rotation angle of stage i as a fraction of a turn, 2^TURN_FRAC per turn.
  function automatic logic signed [Z_W-1:0] turn_angle(input int i);
    real    r;
    longint v;
    if (i == 0) begin
      v = longint'(1) << (TURN_FRAC - 3);
    end else begin
      r = $atan(2.0 ** (-i)) / TWO_PI * (2.0 ** TURN_FRAC);
      v = longint'(r);
    end
    return v[Z_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/phm_pair_if.sv
// Input channel: one beat carries a pair of points.
`default_nettype none

interface phm_pair_if import phm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] from_x;
  logic signed [FIELD_W-1:0] from_y;
  logic signed [FIELD_W-1:0] to_x;
  logic signed [FIELD_W-1:0] to_y;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  input ready);
  modport sink   (input valid, input from_x, input from_y, input to_x, input to_y,
                  output ready);
endinterface

`default_nettype wire

FILE: src/phm_heading_if.sv
// Output channel: one beat carries one heading.
`default_nettype none

interface phm_heading_if import phm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

FILE: src/phm_front.sv
// Front end: coordinate differences, magnitudes and normalizing shift.
`default_nettype none

module phm_front import phm_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [FIELD_W-1:0] from_x,
  input  wire logic signed [FIELD_W-1:0] from_y,
  input  wire logic signed [FIELD_W-1:0] to_x,
  input  wire logic signed [FIELD_W-1:0] to_y,
  output logic                           out_valid,
  output logic signed [XY_W-1:0]         out_x,
  output logic signed [XY_W-1:0]         out_y,
  output phm_flags_t                     out_flags
);

  localparam int DW       = COORD_WIDTH + 1;
  localparam int HALF_STP = NORM_STEPS / 2;

  logic signed [DW-1:0] fx, fy, tx, ty;
  logic signed [DW-1:0] dx1, dy1;
  logic                 v1, v2, v3;
  logic [DW-1:0]        adx, ady;
  logic [XY_W-1:0]      ax2, ay2, ax3, ay3, nx3, ny3, nx4, ny4;
  phm_flags_t           f_new, f2, f3;

  // Keep the low COORD_WIDTH bits, sign-extended by one
  assign fx = {from_x[COORD_WIDTH-1], from_x[COORD_WIDTH-1:0]};
  assign fy = {from_y[COORD_WIDTH-1], from_y[COORD_WIDTH-1:0]};
  assign tx = {to_x[COORD_WIDTH-1], to_x[COORD_WIDTH-1:0]};
  assign ty = {to_y[COORD_WIDTH-1], to_y[COORD_WIDTH-1:0]};

  always_comb begin
    f_new.vert   = (dx1 == '0);
    f_new.dx_pos = !dx1[DW-1] && (dx1 != '0);
    f_new.dy_pos = !dy1[DW-1] && (dy1 != '0);
    f_new.neg    = (dx1[DW-1] != dy1[DW-1]) && (dy1 != '0);
    adx          = dx1[DW-1] ? DW'(-dx1) : DW'(dx1);
    ady          = dy1[DW-1] ? DW'(-dy1) : DW'(dy1);
  end

  // Coarse shifts first, fine shifts one stage later
  always_comb begin
    nx3 = ax2;
    ny3 = ay2;
    for (int k = NORM_STEPS - 1; k >= HALF_STP; k--) begin
      if (((nx3 | ny3) >> (NORM_BIT + 1 - (1 << k))) == '0) begin
        nx3 = nx3 << (1 << k);
        ny3 = ny3 << (1 << k);
      end
    end
  end

  always_comb begin
    nx4 = ax3;
    ny4 = ay3;
    for (int k = HALF_STP - 1; k >= 0; k--) begin
      if (((nx4 | ny4) >> (NORM_BIT + 1 - (1 << k))) == '0) begin
        nx4 = nx4 << (1 << k);
        ny4 = ny4 << (1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1       <= tx - fx;
      dy1       <= ty - fy;
      ax2       <= XY_W'(adx);
      ay2       <= XY_W'(ady);
      f2        <= f_new;
      ax3       <= nx3;
      ay3       <= ny3;
      f3        <= f2;
      out_x     <= signed'(nx4);
      out_y     <= signed'(ny4);
      out_flags <= f3;
    end
  end

endmodule

`default_nettype wire

FILE: src/phm_cordic.sv
// Vectoring rotator: one registered micro-rotation per stage.
`default_nettype none

module phm_cordic import phm_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [XY_W-1:0]  in_x,
  input  wire logic signed [XY_W-1:0]  in_y,
  input  wire phm_flags_t              in_flags,
  output logic                         out_valid,
  output logic signed [Z_W-1:0]        out_z,
  output phm_flags_t                   out_flags
);

  logic signed [XY_W-1:0] x [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] y [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  z [0:CORDIC_STAGES];
  phm_flags_t             fl [0:CORDIC_STAGES];
  logic                   v [0:CORDIC_STAGES];

  assign x[0]  = in_x;
  assign y[0]  = in_y;
  assign z[0]  = '0;
  assign fl[0] = in_flags;
  assign v[0]  = in_valid;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ANG = turn_angle(i);
    logic signed [XY_W-1:0] xs, ys;

    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    // Rotate toward the x axis: sign of y picks the direction
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y[i][XY_W-1]) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + ANG;
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - ANG;
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  assign out_valid = v[CORDIC_STAGES];
  assign out_z     = z[CORDIC_STAGES];
  assign out_flags = fl[CORDIC_STAGES];

endmodule

`default_nettype wire

FILE: src/phm_scale.sv
// Angle clamp, scaling to millidegrees and quadrant fold into the heading.
`default_nettype none

module phm_scale import phm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic signed [Z_W-1:0] in_z,
  input  wire phm_flags_t            in_flags,
  output logic                       out_valid,
  output logic signed [HEAD_W-1:0]   out_heading
);

  logic [ZC_W-1:0]          zc, zc1;
  logic [PL_W-1:0]          plo2;
  logic [PH_W-1:0]          phi2;
  logic [SUM_W-1:0]         sum;
  logic [MDEG_W-1:0]        m3;
  logic signed [HEAD_W-1:0] ms, term, base, head;
  logic                     v1, v2, v3;
  phm_flags_t               f1, f2, f3;

  // Clamp to the first quadrant
  always_comb begin
    if (in_z[Z_W-1]) begin
      zc = '0;
    end else if (in_z[Z_W-1:ZC_W] != '0) begin
      zc = '1;
    end else begin
      zc = in_z[ZC_W-1:0];
    end
  end

  assign sum = {phi2, {ZL_W{1'b0}}} + SUM_W'(plo2);

  always_comb begin
    ms   = {{(HEAD_W - MDEG_W){1'b0}}, m3};
    term = f3.neg ? ms : -ms;
    if (f3.vert) begin
      base = f3.dy_pos ? HEAD_DOWN : HEAD_UP;
      head = base;
    end else begin
      base = f3.dx_pos ? HEAD_RIGHT : HEAD_LEFT;
      head = base + term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zc1         <= zc;
      f1          <= in_flags;
      plo2        <= PL_W'(zc1[ZL_W-1:0]) * PL_W'(MDEG_PER_TURN);
      phi2        <= PH_W'(zc1[ZC_W-1:ZL_W]) * PH_W'(MDEG_PER_TURN);
      f2          <= f1;
      m3          <= sum[SUM_W-1:TURN_FRAC];
      f3          <= f2;
      out_heading <= head;
    end
  end

endmodule

`default_nettype wire

FILE: src/phm_skid.sv
// Output register with a one-entry skid stage; frees the pipeline from downstream ready.
`default_nettype none

module phm_skid import phm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     up_valid,
  input  wire logic signed [HEAD_W-1:0] up_heading,
  output logic                          up_ready,
  phm_heading_if.source                 result
);

  logic                     out_valid;
  logic signed [HEAD_W-1:0] out_heading;
  logic                     skid_valid;
  logic signed [HEAD_W-1:0] skid_heading;
  logic                     drain;

  assign up_ready       = !skid_valid;
  assign drain          = !out_valid || result.ready;
  assign result.valid   = out_valid;
  assign result.heading = out_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= up_valid;
      end
    end else if (up_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_heading <= skid_valid ? skid_heading : up_heading;
    end else if (!skid_valid) begin
      skid_heading <= up_heading;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the output register is empty");

  a_spill: assert property (@(posedge clk) disable iff (rst)
    (up_valid && up_ready && out_valid && !result.ready) |=> skid_valid)
    else $error("beat arriving at a stalled output was not caught by the skid stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result.ready) |=> !skid_valid)
    else $error("skid stage did not empty when the output was taken");
`endif

endmodule

`default_nettype wire

FILE: src/point_heading_millidegrees.sv
// Top level of the point-to-point heading pipeline.
`default_nettype none

// Heading from one point to another in millidegrees, screen convention (y grows
// downward). Each beat on points carries from_x/from_y/to_x/to_y; each beat on
// result carries one heading in [-89999, 270000]. The block takes one point pair
// per clock while the skid stage is not full and keeps no state between items.
// An accepted input beat passes through four front-end stages that form dx/dy,
// take magnitudes and normalize them so the larger one lands at bit 58, then one
// registered CORDIC micro-rotation per stage, then four stages that clamp the
// angle, scale it by 360000 in two partial products of its 19-bit halves and
// fold the quadrant into the heading, and finally the output register. A
// vertical line (dx == 0) yields 270000 when dy > 0 and 90000 otherwise. Only
// the low COORD_WIDTH bits of each coordinate are used, sign-extended. The
// whole pipeline advances together and halts only while the skid stage behind
// the output register is full, so points.ready depends on registered state
// alone; a stall loses or repeats no beat.
module point_heading_millidegrees import phm_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  phm_pair_if.sink      points,
  phm_heading_if.source result
);

  logic                     en;
  logic                     fe_valid;
  logic signed [XY_W-1:0]   fe_x, fe_y;
  phm_flags_t               fe_flags;
  logic                     cr_valid;
  logic signed [Z_W-1:0]    cr_z;
  phm_flags_t               cr_flags;
  logic                     sc_valid;
  logic signed [HEAD_W-1:0] sc_heading;

  // Accept a beat whenever the pipeline advances
  assign points.ready = en;

  phm_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (points.valid),
    .from_x    (points.from_x),
    .from_y    (points.from_y),
    .to_x      (points.to_x),
    .to_y      (points.to_y),
    .out_valid (fe_valid),
    .out_x     (fe_x),
    .out_y     (fe_y),
    .out_flags (fe_flags)
  );

  phm_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fe_valid),
    .in_x      (fe_x),
    .in_y      (fe_y),
    .in_flags  (fe_flags),
    .out_valid (cr_valid),
    .out_z     (cr_z),
    .out_flags (cr_flags)
  );

  phm_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (cr_valid),
    .in_z        (cr_z),
    .in_flags    (cr_flags),
    .out_valid   (sc_valid),
    .out_heading (sc_heading)
  );

  // Hold the pipeline only while the skid stage is occupied
  phm_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (sc_valid),
    .up_heading (sc_heading),
    .up_ready   (en),
    .result     (result)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for the point-to-point heading pipeline.

// Tracks the headings owed by the block and checks each one as it leaves.
class heading_board;
  localparam int STAGES    = phm_pkg::CORDIC_STAGES_DEF;
  localparam int TURN_BITS = 40;
  localparam longint unsigned FIX_ONE   = 64'd1 << 60;
  localparam longint unsigned NORM_FLOOR = 64'd1 << 58;
  localparam longint Z_CEIL = (longint'(1) << (TURN_BITS - 2)) - 1;

  longint turn_step [STAGES];
  logic signed [phm_pkg::HEAD_W-1:0] expected [$];
  int errors;

  function new();
    longint unsigned two_pi;
    int i;
    // 2*pi from Machin's formula with 60 fraction bits
    two_pi = 8 * (4 * atan_recip(5) - atan_recip(239));
    turn_step[0] = longint'(1) << (TURN_BITS - 3);
    for (i = 1; i < STAGES; i++)
      turn_step[i] = turn_units(atan_pow2(i), two_pi);
    errors = 0;
  endfunction

  // atan(1/n) as a fixed-point series
  function longint unsigned atan_recip(longint unsigned n);
    longint unsigned term, sum, k, q;
    term = FIX_ONE / n;
    sum  = 0;
    k    = 0;
    while (term != 0) begin
      q = term / (2 * k + 1);
      if (k[0] == 1'b0) sum += q;
      else sum -= q;
      term /= n * n;
      k++;
    end
    return sum;
  endfunction

  // atan(2^-i) as a fixed-point series
  function longint unsigned atan_pow2(int i);
    longint unsigned term, sum, k, q;
    int sh;
    term = FIX_ONE >> i;
    sum  = 0;
    k    = 0;
    sh   = 2 * i;
    while (term != 0) begin
      q = term / (2 * k + 1);
      if (k[0] == 1'b0) sum += q;
      else sum -= q;
      term = (sh >= 64 || sh == 0) ? 64'd0 : (term >> sh);
      k++;
    end
    return sum;
  endfunction

  // Round a/p to a fraction of a turn with TURN_BITS fraction bits.
  function longint turn_units(longint unsigned a, longint unsigned p);
    longint unsigned rem, q;
    int b;
    rem = a;
    q   = 0;
    for (b = 0; b <= TURN_BITS; b++) begin
      rem <<= 1;
      q   <<= 1;
      if (rem >= p) begin
        rem -= p;
        q |= 64'd1;
      end
    end
    return longint'((q + 1) >> 1);
  endfunction

  // First-quadrant arctangent of ay/ax in millidegrees, truncated.
  function longint arc_mdeg(longint unsigned ax, longint unsigned ay);
    longint unsigned top;
    longint x, y, z, xs, ys;
    int i;
    top = (ax > ay) ? ax : ay;
    while (top < NORM_FLOOR) begin
      ax  <<= 1;
      ay  <<= 1;
      top <<= 1;
    end
    x = longint'(ax);
    y = longint'(ay);
    z = 0;
    for (i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += turn_step[i];
      end else begin
        x -= ys;
        y += xs;
        z -= turn_step[i];
      end
    end
    if (z < 0) z = 0;
    if (z > Z_CEIL) z = Z_CEIL;
    return (z * 360000) >>> TURN_BITS;
  endfunction

  function void note_points(logic signed [31:0] fx, logic signed [31:0] fy,
                            logic signed [31:0] tx, logic signed [31:0] ty);
    longint dx, dy, a, head;
    logic signed [phm_pkg::HEAD_W-1:0] want;
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    if (dx == 0) begin
      head = (dy > 0) ? longint'(phm_pkg::HEAD_DOWN) : longint'(phm_pkg::HEAD_UP);
    end else begin
      a = arc_mdeg((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
      if (((dx < 0) != (dy < 0)) && dy != 0) a = -a;
      head = (dx > 0) ? -a : longint'(phm_pkg::HEAD_LEFT) - a;
    end
    want = head[phm_pkg::HEAD_W-1:0];
    expected.push_back(want);
  endfunction

  task report_mismatch(string what);
    $display("tb_top: mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task check_heading(logic signed [phm_pkg::HEAD_W-1:0] got);
    logic signed [phm_pkg::HEAD_W-1:0] want;
    if (expected.size() == 0) begin
      report_mismatch($sformatf("heading %0d with nothing pending", got));
    end else begin
      want = expected.pop_front();
      if (got !== want) report_mismatch($sformatf("heading %0d, predicted %0d", got, want));
    end
  endtask

  function int pending();
    return expected.size();
  endfunction
endclass

module tb_top;
  import phm_pkg::*;

  // Abort once this many cycles pass with no beat on either channel.
  localparam int IDLE_LIMIT     = 2000;
  localparam int RANDOM_ITEMS   = 2000;
  // The last stretch of items runs with no idling on either side.
  localparam int CALM_ITEMS     = 200;
  // One long receiver hold-off once this many pairs are in, long enough to
  // back up the whole pipeline and the skid stage behind it.
  localparam int SQUEEZE_AT     = 400;
  localparam int SQUEEZE_CYCLES = 300;
  // Drain wait after the last owed heading; longer than the pipeline latency at the defaults.
  localparam int DRAIN_CYCLES   = 64;

  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

  logic clk;
  logic rst;

  phm_pair_if    points_ch ();
  phm_heading_if heading_ch ();

  point_heading_millidegrees dut (
    .clk    (clk),
    .rst    (rst),
    .points (points_ch),
    .result (heading_ch)
  );

  heading_board board;
  int unsigned  fed;
  int unsigned  idle_run;
  bit           calm;
  bit           squeezed;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Observe both channels at the clock edge. Drivers update by nonblocking
  // assignment, so the values read here are the ones the DUT saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (points_ch.valid && points_ch.ready) begin
        board.note_points(points_ch.from_x, points_ch.from_y, points_ch.to_x, points_ch.to_y);
        fed++;
      end
      if (heading_ch.valid && heading_ch.ready) board.check_heading(heading_ch.heading);
      if ((points_ch.valid && points_ch.ready) || (heading_ch.valid && heading_ch.ready))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Present one point pair and hold it until the block takes the beat.
  task automatic offer_pair(input logic signed [31:0] fx, input logic signed [31:0] fy,
                            input logic signed [31:0] tx, input logic signed [31:0] ty);
    points_ch.valid  <= 1'b1;
    points_ch.from_x <= fx;
    points_ch.from_y <= fy;
    points_ch.to_x   <= tx;
    points_ch.to_y   <= ty;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
  endtask

  function automatic int small_step();
    return int'($urandom_range(0, 2000)) - 1000;
  endfunction

  function automatic logic signed [31:0] corner();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Pick a pair from a mix of shapes: fully random, short segments, vertical,
  // horizontal, near-diagonal, near-vertical (hits the angle clamp) and
  // corner values of the coordinate range.
  task automatic offer_random();
    logic signed [31:0] fx, fy, tx, ty;
    int d;
    fx = $urandom;
    fy = $urandom;
    tx = $urandom;
    ty = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4: begin
        tx = fx + small_step();
        ty = fy + small_step();
      end
      5: tx = fx;
      6: ty = fy;
      7: begin
        d  = small_step();
        tx = fx + d;
        ty = ($urandom_range(0, 1) ? fy + d : fy - d) + small_step() / 300;
      end
      8: tx = fx + $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
      default: begin
        fx = corner();
        fy = corner();
        tx = corner();
        ty = corner();
      end
    endcase
    offer_pair(fx, fy, tx, ty);
  endtask

  // Sender: directed pairs first, then random ones with bursts of idling.
  initial begin
    int i;
    int gap_pct;
    board = new();
    fed      = 0;
    idle_run = 0;
    calm     = 1'b0;
    squeezed = 1'b0;
    gap_pct  = 0;
    rst              <= 1'b1;
    points_ch.valid  <= 1'b0;
    points_ch.from_x <= '0;
    points_ch.from_y <= '0;
    points_ch.to_x   <= '0;
    points_ch.to_y   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Vertical line: down, up, and the zero-length segment.
    offer_pair(0, 0, 0, 5);
    offer_pair(0, 0, 0, -5);
    offer_pair(7, 7, 7, 7);
    // Horizontal line both ways.
    offer_pair(0, 0, 9, 0);
    offer_pair(0, 0, -9, 0);
    // Full-range diagonals, differences at their largest magnitude.
    offer_pair(CMIN, CMIN, CMAX, CMAX);
    offer_pair(CMAX, CMAX, CMIN, CMIN);
    offer_pair(CMAX, CMIN, CMIN, CMAX);
    offer_pair(CMIN, CMAX, CMAX, CMIN);
    // Near-vertical in every quadrant: the clamp keeps the angle in range.
    offer_pair(0, CMIN, 1, CMAX);
    offer_pair(1, CMIN, 0, CMAX);
    offer_pair(0, CMAX, 1, CMIN);
    offer_pair(1, CMAX, 0, CMIN);
    // Unit diagonals in all four quadrants.
    offer_pair(0, 0, 1, 1);
    offer_pair(0, 0, 1, -1);
    offer_pair(0, 0, -1, 1);
    offer_pair(0, 0, -1, -1);
    // Near-horizontal with the widest dx.
    offer_pair(CMIN, 0, CMAX, 1);
    offer_pair(CMAX, 0, CMIN, -1);
    // A few plain angles.
    offer_pair(0, 0, 3, 4);
    offer_pair(0, 0, -4000, 3000);
    offer_pair(-1, -1, 0, 0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      // Re-pick the idle density now and then so quiet stretches occur too.
      if (i % 128 == 0) gap_pct = $urandom_range(0, 2) * 15;
      offer_random();
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
        points_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    points_ch.valid <= 1'b0;

    // Drain: everything owed must arrive, then allow the pipeline depth to
    // flush out anything extra.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off to back up the pipe,
  // and steady acceptance once the run goes calm.
  initial begin
    int stall_pct;
    int cyc;
    stall_pct = 0;
    cyc       = 0;
    heading_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (cyc % 128 == 0) stall_pct = $urandom_range(0, 2) * 12;
      if (!squeezed && fed >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        heading_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        cyc += SQUEEZE_CYCLES;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        heading_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        cyc++;
      end else begin
        heading_ch.ready <= 1'b1;
        @(posedge clk);
        cyc++;
      end
    end
  end

endmodule
